[rtl/gae_advantage_scan_top_assert.svh]
// Assertion macros for the advantage scan top level.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef GAE_ADVANTAGE_SCAN_TOP_ASSERT_SVH
`define GAE_ADVANTAGE_SCAN_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define GAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define GAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gas_pkg.sv]
package gas_pkg;

    // Fixed field widths
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int DATA_W            = 32;
    localparam int FACTOR_W          = 17;
    localparam int DELTA_W           = DATA_W + 2;
    localparam int SUM_W             = DELTA_W + 1;
    localparam int CLAMP_UNITS       = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISCOUNT = 2'd0,
        REG_LAMBDA   = 2'd1,
        REG_SCALE    = 2'd2,
        REG_NORM     = 2'd3
    } cfg_reg_t;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'd65536;
    localparam logic [DATA_W-1:0]   SCALE_RESET  = 32'd65536;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One classified step, ready for the recurrence
    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic signed [DATA_W-1:0]  reward;
        logic signed [DATA_W-1:0]  value;
        logic                      cont;
        logic                      clear;
    } step_t;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] count;
    } queue_stat_t;

    // Width of a factor in [0, 1.0]: must hold both the register and 1.0
    function automatic int factor_width(input int frac);
        return (frac + 1 > FACTOR_W) ? frac + 1 : FACTOR_W;
    endfunction

endpackage

[rtl/gas_if.sv]
// Step channel: one trajectory step per transfer
interface gas_step_if;
    import gas_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] reward;
    logic                     done_flag;
    logic                     truncated_flag;
    logic signed [DATA_W-1:0] value_estimate;
    logic signed [DATA_W-1:0] next_value;
    logic                     clear_running;

    modport source (
        output valid, reward, done_flag, truncated_flag, value_estimate, next_value,
               clear_running,
        input  ready
    );

    modport sink (
        input  valid, reward, done_flag, truncated_flag, value_estimate, next_value,
               clear_running,
        output ready
    );
endinterface

// Result channel: advantage, return and value target per transfer
interface gas_result_if;
    import gas_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] advantage;
    logic signed [DATA_W-1:0] return_value;
    logic signed [DATA_W-1:0] value_target;

    modport source (
        output valid, advantage, return_value, value_target,
        input  ready
    );

    modport sink (
        input  valid, advantage, return_value, value_target,
        output ready
    );
endinterface

[rtl/gas_cfg.sv]
module gas_cfg
    import gas_pkg::*;
#(
    parameter  int FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int GW        = factor_width(FRAC_BITS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [GW-1:0]         gamma,
    output logic [GW-1:0]         gamma_lambda,
    output logic [DATA_W-1:0]     reward_scale,
    output logic                  normalize_enable
);

    localparam logic [GW-1:0] UNIT_ONE = GW'(1) << FRAC_BITS;

    logic [FACTOR_W-1:0] discount_reg;
    logic [FACTOR_W-1:0] lambda_reg;
    logic [DATA_W-1:0]   scale_reg;
    logic                norm_reg;
    logic [GW-1:0]       gamma_reg;
    logic [GW-1:0]       gl_reg;

    logic [FACTOR_W-1:0] discount_wr;
    logic [FACTOR_W-1:0] lambda_wr;
    logic [GW-1:0]       gamma_next;
    logic [GW-1:0]       lambda_next;
    logic [2*GW-1:0]     gl_prod;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg <= FACTOR_RESET;
            lambda_reg   <= FACTOR_RESET;
            scale_reg    <= SCALE_RESET;
            norm_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DISCOUNT: discount_reg <= cfg_data[FACTOR_W-1:0];
                REG_LAMBDA:   lambda_reg   <= cfg_data[FACTOR_W-1:0];
                REG_SCALE:    scale_reg    <= cfg_data[DATA_W-1:0];
                REG_NORM:     norm_reg     <= cfg_data[0];
            endcase
        end
    end

    // Factors above 1.0 are held at 1.0; gamma*lambda is formed once here.
    // A write is folded in at its own edge so the next step sees it.
    always_comb
    begin
        discount_wr = discount_reg;
        lambda_wr   = lambda_reg;
        if (cfg_wr_en && (cfg_index == REG_DISCOUNT))
            discount_wr = cfg_data[FACTOR_W-1:0];
        if (cfg_wr_en && (cfg_index == REG_LAMBDA))
            lambda_wr = cfg_data[FACTOR_W-1:0];
        gamma_next  = (GW'(discount_wr) > UNIT_ONE) ? UNIT_ONE : GW'(discount_wr);
        lambda_next = (GW'(lambda_wr) > UNIT_ONE) ? UNIT_ONE : GW'(lambda_wr);
        gl_prod     = gamma_next * lambda_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= UNIT_ONE;
            gl_reg    <= UNIT_ONE;
        end
        else
        begin
            gamma_reg <= gamma_next;
            gl_reg    <= gl_prod[FRAC_BITS +: GW];
        end
    end

    assign gamma            = gamma_reg;
    assign gamma_lambda     = gl_reg;
    assign reward_scale     = scale_reg;
    assign normalize_enable = norm_reg;

endmodule

[rtl/gas_front.sv]
module gas_front
    import gas_pkg::*;
#(
    parameter  int FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int GW        = factor_width(FRAC_BITS),
    localparam int RSP_W     = 2 * DATA_W + 1,
    localparam int GVP_W     = DATA_W + GW + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    gas_step_if.sink          step,
    input  logic [GW-1:0]     gamma,
    input  logic [DATA_W-1:0] reward_scale,
    input  logic              normalize_enable,
    input  queue_stat_t       q_stat,
    output logic              q_push,
    output step_t             q_data
);

    localparam logic signed [RSP_W-1:0] CLAMP_HI = RSP_W'(CLAMP_UNITS) << FRAC_BITS;
    localparam logic signed [RSP_W-1:0] CLAMP_LO = -CLAMP_HI;

    logic                     f1_valid_reg;
    logic                     f1_valid_next;
    logic signed [RSP_W-1:0]  rs_prod_reg;
    logic signed [GVP_W-1:0]  gv_prod_reg;
    logic signed [DATA_W-1:0] reward_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     done_reg;
    logic                     trunc_reg;
    logic                     clear_reg;

    logic                     accept;
    logic signed [RSP_W-1:0]  rs_shift;
    logic signed [GVP_W-1:0]  gv_shift;
    logic signed [DATA_W-1:0] nr;
    logic signed [DELTA_W-1:0] gv_term;
    logic signed [DELTA_W-1:0] delta;

    // Handshake: the product stage drains into the queue
    assign q_push     = f1_valid_reg && !q_stat.full;
    assign step.ready = !f1_valid_reg || !q_stat.full;
    assign accept     = step.valid && step.ready;

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
            f1_valid_next = 1'b1;
        else if (q_push)
            f1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= f1_valid_next;
    end

    // Product stage: scaled reward and discounted next value
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rs_prod_reg <= step.reward * $signed({1'b0, reward_scale});
            gv_prod_reg <= step.next_value * $signed({1'b0, gamma});
            reward_reg  <= step.reward;
            value_reg   <= step.value_estimate;
            done_reg    <= step.done_flag;
            trunc_reg   <= step.truncated_flag;
            clear_reg   <= step.clear_running;
        end
    end

    // TD error: when normalizing, clamp the scaled reward to +/-10; drop next value on termination
    always_comb
    begin
        rs_shift = rs_prod_reg >>> FRAC_BITS;
        gv_shift = gv_prod_reg >>> FRAC_BITS;
        if (!normalize_enable)
            nr = reward_reg;
        else if (rs_shift > CLAMP_HI)
            nr = CLAMP_HI[DATA_W-1:0];
        else if (rs_shift < CLAMP_LO)
            nr = CLAMP_LO[DATA_W-1:0];
        else
            nr = rs_shift[DATA_W-1:0];
        gv_term = done_reg ? '0 : gv_shift[DELTA_W-1:0];
        delta   = DELTA_W'(nr) + gv_term - DELTA_W'(value_reg);
    end

    always_comb
    begin
        q_data.delta  = delta;
        q_data.reward = reward_reg;
        q_data.value  = value_reg;
        q_data.cont   = !done_reg && !trunc_reg;
        q_data.clear  = clear_reg;
    end

endmodule

[rtl/gas_queue.sv]
module gas_queue
    import gas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  step_t       push_data,
    input  logic        pop,
    output step_t       pop_data,
    output queue_stat_t stat
);

    step_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CW'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CW'(1);
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

[rtl/gas_back.sv]
module gas_back
    import gas_pkg::*;
#(
    parameter  int FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int GW        = factor_width(FRAC_BITS),
    localparam int PW        = DATA_W + GW + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [GW-1:0] gamma,
    input  logic [GW-1:0] gamma_lambda,
    input  queue_stat_t   q_stat,
    input  step_t         q_data,
    output logic          q_pop,
    gas_result_if.source  result
);

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SUM_MAX)
            r = {1'b0, {(DATA_W - 1){1'b1}}};
        else if (x < SUM_MIN)
            r = {1'b1, {(DATA_W - 1){1'b0}}};
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

    // Recurrence stage: running sums double as its result registers
    logic                     e_valid_reg;
    logic                     e_valid_next;
    logic signed [DATA_W-1:0] run_adv_reg;
    logic signed [DATA_W-1:0] run_ret_reg;
    logic signed [DATA_W-1:0] e_value_reg;

    // Output register
    logic                     o_valid_reg;
    logic                     o_valid_next;
    logic signed [DATA_W-1:0] o_adv_reg;
    logic signed [DATA_W-1:0] o_ret_reg;
    logic signed [DATA_W-1:0] o_vt_reg;

    logic                     o_ready;
    logic                     e_ready;
    logic signed [DATA_W-1:0] adv_prev;
    logic signed [DATA_W-1:0] ret_prev;
    logic signed [PW-1:0]     adv_prod;
    logic signed [PW-1:0]     ret_prod;
    logic signed [PW-1:0]     adv_shift;
    logic signed [PW-1:0]     ret_shift;
    logic signed [SUM_W-1:0]  adv_sum;
    logic signed [SUM_W-1:0]  ret_sum;
    logic signed [DATA_W-1:0] adv_next;
    logic signed [DATA_W-1:0] ret_next;
    logic signed [DATA_W-1:0] vt_next;

    // Stage handshake
    assign o_ready = !o_valid_reg || result.ready;
    assign e_ready = !e_valid_reg || o_ready;
    assign q_pop   = !q_stat.empty && e_ready;

    // One multiply-add per running sum, cleared first if asked
    always_comb
    begin
        adv_prev  = q_data.clear ? '0 : run_adv_reg;
        ret_prev  = q_data.clear ? '0 : run_ret_reg;
        adv_prod  = adv_prev * $signed({1'b0, gamma_lambda});
        ret_prod  = ret_prev * $signed({1'b0, gamma});
        adv_shift = adv_prod >>> FRAC_BITS;
        ret_shift = ret_prod >>> FRAC_BITS;
        adv_sum   = SUM_W'(q_data.delta);
        ret_sum   = SUM_W'(q_data.reward);
        if (q_data.cont)
        begin
            adv_sum = adv_sum + adv_shift[SUM_W-1:0];
            ret_sum = ret_sum + ret_shift[SUM_W-1:0];
        end
        adv_next = sat_sum(adv_sum);
        ret_next = sat_sum(ret_sum);
        vt_next  = sat_sum(SUM_W'(e_value_reg) + SUM_W'(run_adv_reg));
    end

    always_comb
    begin
        e_valid_next = e_valid_reg;
        if (q_pop)
            e_valid_next = 1'b1;
        else if (o_ready)
            e_valid_next = 1'b0;
        o_valid_next = o_ready ? e_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            run_adv_reg <= '0;
            run_ret_reg <= '0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            o_valid_reg <= o_valid_next;
            if (q_pop)
            begin
                run_adv_reg <= adv_next;
                run_ret_reg <= ret_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
            e_value_reg <= q_data.value;
        if (o_ready && e_valid_reg)
        begin
            o_adv_reg <= run_adv_reg;
            o_ret_reg <= run_ret_reg;
            o_vt_reg  <= vt_next;
        end
    end

    assign result.valid        = o_valid_reg;
    assign result.advantage    = o_adv_reg;
    assign result.return_value = o_ret_reg;
    assign result.value_target = o_vt_reg;

endmodule

[rtl/gae_advantage_scan_top.sv]
// Channel   Role     Payload                                              Transfer
// step      sink     reward, done/truncated flags, value, next value,     valid & ready
//                    clear_running
// result    source   advantage, return_value, value_target                valid & ready
// cfg       write    cfg_index selects register, cfg_data holds value     cfg_wr_en
//
// One step per clock sustained while result is ready; the limit is the multiply-add
// loop on the running advantage and return in the back stage.
// Path: an accepted step passes the product stage, the queue, the recurrence
// stage and the output register, and is then offered as a result.
// Reset (rst_n, async, active low) clears running sums, queue and registers.
// A four-entry queue between front and back lets each side stall on its own.
`include "gae_advantage_scan_top_assert.svh"

module gae_advantage_scan_top
    import gas_pkg::*;
#(
    parameter  int FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int GW        = factor_width(FRAC_BITS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gas_step_if.sink              step,
    gas_result_if.source          result
);

    logic [GW-1:0]     gamma;
    logic [GW-1:0]     gamma_lambda;
    logic [DATA_W-1:0] reward_scale;
    logic              normalize_enable;
    logic              q_push;
    logic              q_pop;
    step_t             q_in;
    step_t             q_out;
    queue_stat_t       q_stat;

    gas_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .gamma            (gamma),
        .gamma_lambda     (gamma_lambda),
        .reward_scale     (reward_scale),
        .normalize_enable (normalize_enable)
    );

    gas_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .gamma            (gamma),
        .reward_scale     (reward_scale),
        .normalize_enable (normalize_enable),
        .q_stat           (q_stat),
        .q_push           (q_push),
        .q_data           (q_in)
    );

    gas_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    gas_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .gamma        (gamma),
        .gamma_lambda (gamma_lambda),
        .q_stat       (q_stat),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .result       (result)
    );

    // Front never writes a full queue, back never reads an empty one
    `GAS_ASSERT_NOW(a_queue_no_overflow, q_push, !q_stat.full, "queue written while full")
    `GAS_ASSERT_NOW(a_queue_no_underflow, q_pop, !q_stat.empty, "queue read while empty")
    // Fill level follows the transfers on both sides
    `GAS_ASSERT_NEXT(a_queue_count, 1'b1, q_stat.count == $past(q_stat.count) + QUEUE_CW'($past(q_push)) - QUEUE_CW'($past(q_pop)), "queue fill level lost track")

endmodule
